// ===== sv/ifal_pkg.sv =====
// ----------------------------------------------------------------------------
// ifal_pkg
// Shared codes and types for the indexed free and active list.
// ----------------------------------------------------------------------------
`default_nettype none

package ifal_pkg;

  // Built depth of the pool; the slot and count ports are sized for it
  localparam int POOL_DEPTH = 64;

  typedef enum logic [3:0] {
    CMD_INIT     = 4'd0,
    CMD_ALLOC    = 4'd1,
    CMD_FREE     = 4'd2,
    CMD_ADD      = 4'd3,
    CMD_REMOVE   = 4'd4,
    CMD_REM_FREE = 4'd5,
    CMD_FIRST_A  = 4'd6,
    CMD_FIRST_F  = 4'd7,
    CMD_NEXT     = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_RD,
    S_USE,
    S_WR1,
    S_WR2,
    S_FIN
  } fsm_state_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NONE  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam int PSLOTS_RESET = 64;

  typedef struct packed {
    logic [1:0] status;
    logic       result_valid;
    logic [5:0] result_slot;
    logic [6:0] active_total;
    logic [6:0] free_total;
    logic       pool_full;
    logic       active_empty;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/ifal_link_mem.sv =====
// ----------------------------------------------------------------------------
// ifal_link_mem
// Link store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ifal_link_mem #(
  parameter int AW = 6,
  parameter int DW = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ifal_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifal_ctrl
// Command sequencer: list heads, count and read-modify-write of the links.
// ----------------------------------------------------------------------------
`default_nettype none

module ifal_ctrl
  import ifal_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_cmd,
  input  wire logic [5:0] in_slot_index,
  input  wire logic [6:0] pool_slots,
  input  wire logic       res_ready,
  output logic            res_load,
  output res_t            res,
  output logic            nwe,
  output logic [$clog2(POOL_DEPTH)-1:0]   nwaddr,
  output logic [$clog2(POOL_DEPTH+1)-1:0] nwdata,
  output logic            nre,
  output logic [$clog2(POOL_DEPTH)-1:0]   nraddr,
  input  wire logic [$clog2(POOL_DEPTH+1)-1:0] nrdata,
  output logic            pwe,
  output logic [$clog2(POOL_DEPTH)-1:0]   pwaddr,
  output logic [$clog2(POOL_DEPTH+1)-1:0] pwdata,
  output logic            pre,
  output logic [$clog2(POOL_DEPTH)-1:0]   praddr,
  input  wire logic [$clog2(POOL_DEPTH+1)-1:0] prdata
);

  localparam int AW   = $clog2(POOL_DEPTH);
  localparam int LW   = $clog2(POOL_DEPTH + 1);
  localparam int CW   = (LW > 7) ? LW : 7;
  localparam int PRST = (PSLOTS_RESET > POOL_DEPTH) ? POOL_DEPTH : PSLOTS_RESET;
  localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(POOL_DEPTH - 1);

  fsm_state_t    state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [LW-1:0] fh_r, fh_nxt, ah_r, ah_nxt, cnt_r, cnt_nxt, psize_r, psize_nxt;
  logic [LW-1:0] pv_r, pv_nxt, nx_r, nx_nxt, rs_r, rs_nxt;
  logic [AW-1:0] sw_r, sw_nxt;
  logic          res_en_r, res_en_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          rv_r, rv_nxt;

  logic [CW-1:0] cfg_ext, sin;
  logic [LW-1:0] psz_cfg, sw_inc;
  logic          need_idx;

  always_comb begin
    cfg_ext = CW'(pool_slots);
    if (cfg_ext == '0) begin
      psz_cfg = LW'(1);
    end else if (cfg_ext > CW'(POOL_DEPTH)) begin
      psz_cfg = NONE;
    end else begin
      psz_cfg = LW'(cfg_ext);
    end
  end

  assign sin    = CW'(in_slot_index);
  assign sw_inc = LW'(sw_r) + LW'(1);
  assign need_idx = (in_cmd == CMD_FREE) || (in_cmd == CMD_ADD) ||
                    (in_cmd == CMD_REMOVE) || (in_cmd == CMD_REM_FREE) ||
                    (in_cmd == CMD_NEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_SWEEP;
      sw_r     <= '0;
      res_en_r <= 1'b0;
      ah_r     <= NONE;
      fh_r     <= '0;
      cnt_r    <= '0;
      psize_r  <= LW'(PRST);
    end else begin
      state_r  <= state_nxt;
      sw_r     <= sw_nxt;
      res_en_r <= res_en_nxt;
      ah_r     <= ah_nxt;
      fh_r     <= fh_nxt;
      cnt_r    <= cnt_nxt;
      psize_r  <= psize_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    s_r   <= s_nxt;
    pv_r  <= pv_nxt;
    nx_r  <= nx_nxt;
    st_r  <= st_nxt;
    rv_r  <= rv_nxt;
    rs_r  <= rs_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    s_nxt      = s_r;
    fh_nxt     = fh_r;
    ah_nxt     = ah_r;
    cnt_nxt    = cnt_r;
    psize_nxt  = psize_r;
    pv_nxt     = pv_r;
    nx_nxt     = nx_r;
    rs_nxt     = rs_r;
    sw_nxt     = sw_r;
    res_en_nxt = res_en_r;
    st_nxt     = st_r;
    rv_nxt     = rv_r;
    nwe = 1'b0; nwaddr = '0; nwdata = '0; nre = 1'b0; nraddr = '0;
    pwe = 1'b0; pwaddr = '0; pwdata = '0; pre = 1'b0; praddr = '0;
    in_stall = (state_r != S_IDLE);
    res_load = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = cmd_t'(in_cmd);
          s_nxt   = sin;
          st_nxt  = STAT_OK;
          rv_nxt  = 1'b0;
          rs_nxt  = '0;
          if (need_idx && (sin >= CW'(psize_r))) begin
            st_nxt    = STAT_RANGE;
            state_nxt = S_FIN;
          end else begin
            case (cmd_t'(in_cmd))
              CMD_INIT: begin
                psize_nxt  = psz_cfg;
                ah_nxt     = NONE;
                fh_nxt     = '0;
                cnt_nxt    = '0;
                sw_nxt     = '0;
                res_en_nxt = 1'b1;
                state_nxt  = S_SWEEP;
              end
              CMD_ALLOC: begin
                if (fh_r == NONE) begin
                  st_nxt    = STAT_NONE;
                  state_nxt = S_FIN;
                end else begin
                  rv_nxt    = 1'b1;
                  rs_nxt    = fh_r;
                  state_nxt = S_RD;
                end
              end
              CMD_FREE:    state_nxt = S_WR2;
              CMD_ADD:     state_nxt = S_WR1;
              CMD_REMOVE, CMD_REM_FREE, CMD_NEXT: state_nxt = S_RD;
              CMD_FIRST_A, CMD_FIRST_F: begin
                if (((cmd_t'(in_cmd) == CMD_FIRST_A) ? ah_r : fh_r) == NONE) begin
                  st_nxt = STAT_NONE;
                end else begin
                  rv_nxt = 1'b1;
                  rs_nxt = (cmd_t'(in_cmd) == CMD_FIRST_A) ? ah_r : fh_r;
                end
                state_nxt = S_FIN;
              end
              default: state_nxt = S_FIN;
            endcase
          end
        end
      end

      S_SWEEP: begin
        // rebuild the free chain, one entry a cycle
        nwe    = 1'b1;
        nwaddr = sw_r;
        nwdata = (sw_inc < psize_r) ? sw_inc : NONE;
        pwe    = 1'b1;
        pwaddr = sw_r;
        pwdata = NONE;
        if (sw_r == LAST) begin
          state_nxt = res_en_r ? S_FIN : S_IDLE;
        end else begin
          sw_nxt = sw_r + AW'(1);
        end
      end

      S_RD: begin
        nre    = 1'b1;
        pre    = 1'b1;
        nraddr = (cmd_r == CMD_ALLOC) ? fh_r[AW-1:0] : s_r[AW-1:0];
        praddr = s_r[AW-1:0];
        state_nxt = S_USE;
      end

      S_USE: begin
        case (cmd_r)
          CMD_ALLOC: begin
            fh_nxt    = (nrdata < psize_r) ? nrdata : NONE;
            state_nxt = S_FIN;
          end
          CMD_NEXT: begin
            if (nrdata < psize_r) begin
              rv_nxt = 1'b1;
              rs_nxt = nrdata;
            end else begin
              st_nxt = STAT_NONE;
            end
            state_nxt = S_FIN;
          end
          default: begin
            pv_nxt    = (prdata < psize_r) ? prdata : NONE;
            nx_nxt    = (nrdata < psize_r) ? nrdata : NONE;
            state_nxt = S_WR1;
          end
        endcase
      end

      S_WR1: begin
        case (cmd_r)
          CMD_ADD: begin
            nwe    = 1'b1;
            nwaddr = s_r[AW-1:0];
            nwdata = ah_r;
            pwe    = 1'b1;
            pwaddr = s_r[AW-1:0];
            pwdata = NONE;
          end
          default: begin
            // unlink: bridge neighbours around the slot
            if (pv_r != NONE) begin
              nwe    = 1'b1;
              nwaddr = pv_r[AW-1:0];
              nwdata = nx_r;
            end else begin
              ah_nxt = nx_r;
            end
            if (nx_r != NONE) begin
              pwe    = 1'b1;
              pwaddr = nx_r[AW-1:0];
              pwdata = pv_r;
            end
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - LW'(1);
            end
            if (cmd_r == CMD_REM_FREE) begin
              if (nx_r == NONE) begin
                st_nxt = STAT_NONE;
              end else begin
                rv_nxt = 1'b1;
                rs_nxt = nx_r;
              end
            end
          end
        endcase
        state_nxt = S_WR2;
      end

      S_WR2: begin
        case (cmd_r)
          CMD_ADD: begin
            if (ah_r != NONE) begin
              pwe    = 1'b1;
              pwaddr = ah_r[AW-1:0];
              pwdata = LW'(s_r);
            end
            ah_nxt = LW'(s_r);
            if (cnt_r < psize_r) begin
              cnt_nxt = cnt_r + LW'(1);
            end
          end
          CMD_REMOVE: begin
            nwe    = 1'b1;
            nwaddr = s_r[AW-1:0];
            nwdata = NONE;
            pwe    = 1'b1;
            pwaddr = s_r[AW-1:0];
            pwdata = NONE;
          end
          default: begin
            // push onto the free list
            nwe    = 1'b1;
            nwaddr = s_r[AW-1:0];
            nwdata = fh_r;
            pwe    = 1'b1;
            pwaddr = s_r[AW-1:0];
            pwdata = NONE;
            fh_nxt = LW'(s_r);
          end
        endcase
        state_nxt = S_FIN;
      end

      S_FIN: begin
        res_load = res_ready;
        if (res_ready) begin
          res_en_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res.status       = st_r;
    res.result_valid = rv_r;
    res.result_slot  = 6'(rs_r);
    res.active_total = 7'(cnt_r);
    res.free_total   = (cnt_r < psize_r) ? 7'(psize_r - cnt_r) : 7'd0;
    res.pool_full    = (fh_r == NONE);
    res.active_empty = (ah_r == NONE);
  end

endmodule

`default_nettype wire

// ===== sv/indexed_free_and_active_list.sv =====
// ----------------------------------------------------------------------------
// indexed_free_and_active_list
// Slot pool kept as a free list and a doubly linked active list.
// ----------------------------------------------------------------------------
// One command in flight at a time, set by the single read-modify-write
//   sequencer over the two link stores.
// Reset: synchronous; a sweep over all POOL_DEPTH entries rebuilds the free
//   chain, with the input stalled until it ends. Configuration is taken
//   meanwhile.
`default_nettype none

module indexed_free_and_active_list
  import ifal_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] in_cmd,
  input  wire logic [5:0] in_slot_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic            out_result_valid,
  output logic [5:0]      out_result_slot,
  output logic [6:0]      out_active_total,
  output logic [6:0]      out_free_total,
  output logic            out_pool_full,
  output logic            out_active_empty,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_pool_slots
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);

  logic [6:0]    pool_slots_r;
  logic          out_valid_r;
  res_t          out_r, res;
  logic          res_ready, res_load;

  logic          nwe, nre, pwe, pre;
  logic [AW-1:0] nwaddr, nraddr, pwaddr, praddr;
  logic [LW-1:0] nwdata, nrdata, pwdata, prdata;

  // Pool size word: always writable, taken in by the next init.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_slots_r <= 7'(PSLOTS_RESET);
    end else if (cfg_valid) begin
      pool_slots_r <= cfg_pool_slots;
    end
  end

  // Output register: the sequencer may finish the next word once this
  // one is taken or if the slot is empty.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_result_valid = out_r.result_valid;
  assign out_result_slot  = out_r.result_slot;
  assign out_active_total = out_r.active_total;
  assign out_free_total   = out_r.free_total;
  assign out_pool_full    = out_r.pool_full;
  assign out_active_empty = out_r.active_empty;

  ifal_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_slot_index (in_slot_index),
    .pool_slots    (pool_slots_r),
    .res_ready     (res_ready),
    .res_load      (res_load),
    .res           (res),
    .nwe           (nwe),
    .nwaddr        (nwaddr),
    .nwdata        (nwdata),
    .nre           (nre),
    .nraddr        (nraddr),
    .nrdata        (nrdata),
    .pwe           (pwe),
    .pwaddr        (pwaddr),
    .pwdata        (pwdata),
    .pre           (pre),
    .praddr        (praddr),
    .prdata        (prdata)
  );

  // Next links: free chain and forward active chain.
  ifal_link_mem #(.AW(AW), .DW(LW)) u_next_mem (
    .clk     (clk),
    .we      (nwe),
    .waddr   (nwaddr),
    .wdata   (nwdata),
    .re      (nre),
    .raddr   (nraddr),
    .rdata_r (nrdata)
  );

  // Previous links: backward active chain.
  ifal_link_mem #(.AW(AW), .DW(LW)) u_prev_mem (
    .clk     (clk),
    .we      (pwe),
    .waddr   (pwaddr),
    .wdata   (pwdata),
    .re      (pre),
    .raddr   (praddr),
    .rdata_r (prdata)
  );

endmodule

`default_nettype wire

// ===== verif/tb_indexed_free_and_active_list.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_free_and_active_list
// Self-checking bench: directed table, pool size runs, then random commands,
// each result word compared against an in-bench model of the free and active lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_indexed_free_and_active_list;
  import ifal_pkg::*;

  localparam int DEPTH = POOL_DEPTH;
  localparam logic [6:0] NIL = 7'd64;
  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] in_cmd = '0;
  logic [5:0] in_slot_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic       out_result_valid;
  logic [5:0] out_result_slot;
  logic [6:0] out_active_total;
  logic [6:0] out_free_total;
  logic       out_pool_full;
  logic       out_active_empty;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_pool_slots = '0;

  always #6 clk = ~clk;

  indexed_free_and_active_list DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_slot_index(in_slot_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_valid(out_result_valid),
    .out_result_slot(out_result_slot), .out_active_total(out_active_total),
    .out_free_total(out_free_total), .out_pool_full(out_pool_full),
    .out_active_empty(out_active_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_pool_slots(cfg_pool_slots)
  );

  // Shadow state of the list manager
  logic [6:0] nxt_lnk [DEPTH];
  logic [6:0] prv_lnk [DEPTH];
  logic [6:0] act_head, fre_head, act_cnt, pool_sz, slots_reg;

  res_t expected_words[$];
  res_t last_word;
  int   mismatches = 0;
  int   words_checked = 0;
  int   cmds_sent = 0;
  bit   timed_out = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_off = 0;

  function automatic bit in_pool(logic [6:0] v);
    return v < pool_sz;
  endfunction

  function automatic void rebuild_lists();
    logic [6:0] p;
    p = slots_reg;
    if (p < 7'd1) p = 7'd1;
    if (p > DEPTH) p = 7'(DEPTH);
    pool_sz = p;
    for (int i = 0; i < DEPTH; i++) begin
      nxt_lnk[i] = (i + 1 < p) ? 7'(i + 1) : NIL;
      prv_lnk[i] = NIL;
    end
    act_head = NIL;
    fre_head = '0;
    act_cnt = '0;
  endfunction

  function automatic logic [6:0] unlink_slot(logic [5:0] s);
    logic [6:0] pv, nx;
    pv = in_pool(prv_lnk[s]) ? prv_lnk[s] : NIL;
    nx = in_pool(nxt_lnk[s]) ? nxt_lnk[s] : NIL;
    if (pv == NIL) act_head = nx;
    else nxt_lnk[pv[5:0]] = nx;
    if (nx != NIL) prv_lnk[nx[5:0]] = pv;
    if (act_cnt > 0) act_cnt--;
    return nx;
  endfunction

  function automatic void push_free_slot(logic [5:0] s);
    nxt_lnk[s] = in_pool(fre_head) ? fre_head : NIL;
    prv_lnk[s] = NIL;
    fre_head = {1'b0, s};
  endfunction

  // Apply one command to the shadow lists and return the word it yields
  function automatic res_t list_outcome(logic [3:0] c, logic [5:0] s);
    res_t r;
    logic [6:0] v;
    bit needs_idx;
    r = '0;
    needs_idx = c inside {CMD_FREE, CMD_ADD, CMD_REMOVE, CMD_REM_FREE, CMD_NEXT};
    if (needs_idx && {1'b0, s} >= pool_sz) begin
      r.status = STAT_RANGE;
    end else begin
      case (c)
        CMD_INIT: rebuild_lists();
        CMD_ALLOC: begin
          if (!in_pool(fre_head)) r.status = STAT_NONE;
          else begin
            r.result_slot = fre_head[5:0];
            r.result_valid = 1'b1;
            v = nxt_lnk[fre_head[5:0]];
            fre_head = in_pool(v) ? v : NIL;
          end
        end
        CMD_FREE: push_free_slot(s);
        CMD_ADD: begin
          v = in_pool(act_head) ? act_head : NIL;
          nxt_lnk[s] = v;
          prv_lnk[s] = NIL;
          if (v != NIL) prv_lnk[v[5:0]] = {1'b0, s};
          act_head = {1'b0, s};
          if (act_cnt < pool_sz) act_cnt++;
        end
        CMD_REMOVE: begin
          void'(unlink_slot(s));
          nxt_lnk[s] = NIL;
          prv_lnk[s] = NIL;
        end
        CMD_REM_FREE: begin
          v = unlink_slot(s);
          push_free_slot(s);
          if (v == NIL) r.status = STAT_NONE;
          else begin
            r.result_slot = v[5:0];
            r.result_valid = 1'b1;
          end
        end
        CMD_FIRST_A, CMD_FIRST_F, CMD_NEXT: begin
          v = (c == CMD_FIRST_A) ? act_head : (c == CMD_FIRST_F) ? fre_head : nxt_lnk[s];
          if (!in_pool(v)) r.status = STAT_NONE;
          else begin
            r.result_slot = v[5:0];
            r.result_valid = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (!in_pool(act_head)) act_head = NIL;
    if (!in_pool(fre_head)) fre_head = NIL;
    r.active_total = act_cnt;
    r.free_total = (act_cnt < pool_sz) ? pool_sz - act_cnt : '0;
    r.pool_full = (fre_head == NIL);
    r.active_empty = (act_head == NIL);
    return r;
  endfunction

  // Directed table; a row with fixed set carries a hand-typed expected word
  typedef struct {
    logic [3:0] c;
    logic [5:0] s;
    bit         fixed;
    res_t       word;
  } table_row_t;

  table_row_t directed[$];

  function automatic res_t mk_word(logic [1:0] st, logic rv, logic [5:0] rs,
                                   logic [6:0] at, logic [6:0] ft, logic pf, logic ae);
    res_t r;
    r = '{st, rv, rs, at, ft, pf, ae};
    return r;
  endfunction

  // Drive one word onto the input channel, change on the falling edge
  task automatic send_cmd(logic [3:0] c, logic [5:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_cmd <= c;
    in_slot_index <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmds_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every expected word is back, then let the sequencer settle
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_pool_slots(logic [6:0] val);
    cfg_pool_slots <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slots_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command: mostly sensible list traffic, some noise and bad indexes
  task automatic random_cmd();
    int k;
    logic [5:0] s;
    k = $urandom_range(99);
    s = (k < 8) ? 6'($urandom) : 6'($urandom_range(pool_sz - 1));
    if (k < 2) send_cmd(CMD_INIT, s);
    else if (k < 4) send_cmd(4'($urandom_range(15, 9)), s);
    else if (k < 22) send_cmd(CMD_ALLOC, s);
    else if (k < 36) send_cmd(CMD_ADD, s);
    else if (k < 46) send_cmd(CMD_REMOVE, in_pool(act_head) && k & 1 ? act_head[5:0] : s);
    else if (k < 58) send_cmd(CMD_REM_FREE, in_pool(act_head) && k & 1 ? act_head[5:0] : s);
    else if (k < 70) send_cmd(CMD_FREE, s);
    else if (k < 76) send_cmd(CMD_FIRST_A, s);
    else if (k < 82) send_cmd(CMD_FIRST_F, s);
    else send_cmd(CMD_NEXT, s);
  endtask

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_words.push_back(list_outcome(in_cmd, in_slot_index));
    end
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_result_valid, out_result_slot, out_active_total,
              out_free_total, out_pool_full, out_active_empty};
      last_word = got;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Receiver: stall at random, or hold off entirely when asked
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: count cycles with no handshake on either channel
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    res_t w;
    logic [6:0] small_sizes [6];
    small_sizes[0] = 7'd1;
    small_sizes[1] = 7'd0;
    small_sizes[2] = 7'd100;
    small_sizes[3] = 7'd5;
    small_sizes[4] = 7'd127;
    small_sizes[5] = 7'd3;
    slots_reg = 7'd64;
    rebuild_lists();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: reset picture, extremes, each command
    directed.push_back('{CMD_FIRST_F, 6'd0, 1, mk_word(STAT_OK, 1, 0, 0, 64, 0, 1)});
    directed.push_back('{CMD_FIRST_A, 6'd0, 1, mk_word(STAT_NONE, 0, 0, 0, 64, 0, 1)});
    directed.push_back('{CMD_NEXT, 6'd63, 1, mk_word(STAT_NONE, 0, 0, 0, 64, 0, 1)});
    directed.push_back('{CMD_ALLOC, 6'd0, 1, mk_word(STAT_OK, 1, 0, 0, 64, 0, 1)});
    directed.push_back('{CMD_ADD, 6'd0, 1, mk_word(STAT_OK, 0, 0, 1, 63, 0, 0)});
    directed.push_back('{CMD_ALLOC, 6'd0, 0, '0});
    directed.push_back('{CMD_ADD, 6'd1, 0, '0});
    directed.push_back('{CMD_ADD, 6'd63, 0, '0});
    directed.push_back('{CMD_NEXT, 6'd1, 0, '0});
    directed.push_back('{CMD_REMOVE, 6'd1, 0, '0});
    directed.push_back('{CMD_REM_FREE, 6'd63, 0, '0});
    directed.push_back('{CMD_REM_FREE, 6'd0, 0, '0});
    directed.push_back('{CMD_FREE, 6'd1, 0, '0});
    directed.push_back('{CMD_FIRST_F, 6'd0, 0, '0});
    directed.push_back('{4'd15, 6'd42, 0, '0});
    directed.push_back('{4'd9, 6'd21, 0, '0});
    directed.push_back('{CMD_INIT, 6'd63, 1, mk_word(STAT_OK, 0, 0, 0, 64, 0, 1)});
    foreach (directed[i]) begin
      w = directed[i].word;
      send_cmd(directed[i].c, directed[i].s);
      drain();
      // Hand-typed rows: compare the returned word with the typed one
      if (directed[i].fixed && last_word !== w) begin
        mismatches++;
        if (mismatches <= 10) $display("row %0d: expected %p got %p", i, w, last_word);
      end
    end

    // Small and out-of-range pool sizes: range errors, exhaustion and saturation
    foreach (small_sizes[j]) begin
      write_pool_slots(small_sizes[j]);
      send_cmd(CMD_INIT, 6'd0);
      send_cmd(CMD_ALLOC, 6'd0);
      send_cmd(CMD_ALLOC, 6'd0);
      send_cmd(CMD_FREE, 6'd63);
      send_cmd(CMD_ADD, 6'd0);
      send_cmd(CMD_ADD, 6'd0);
      send_cmd(CMD_ADD, 6'd0);
      send_cmd(CMD_REMOVE, 6'd0);
      send_cmd(CMD_REMOVE, 6'd0);
      send_cmd(CMD_NEXT, 6'd0);
      drain();
    end

    // Random phases at several pool sizes and idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_pool_slots((ph == 3) ? 7'd64 : 7'($urandom_range(64, 1)));
      send_cmd(CMD_INIT, 6'($urandom));
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 61 : 0;
      recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 29 : 0;
      if (ph == 4) begin
        // Hold the receiver off while the sender keeps offering words
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          repeat (20) random_cmd();
        join
      end
      repeat (160) random_cmd();
      drain();
    end

    $display("Ran %0d commands, %0d result words checked, pool sizes 0..127 written.",
             cmds_sent, words_checked);
    $display("Covered range errors, list exhaustion, misuse and receiver hold-off.");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
